>>> src/scc_pkg.sv
// Shared command and status types for the strongly connected component counter.
`timescale 1ns / 1ps
package scc_pkg;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_INIT,
		OP_NEXT_ROOT,
		OP_ENTER_ROOT,
		OP_PUSH,
		OP_NEXT_J,
		OP_READ_VO,
		OP_UPD_LOW,
		OP_READ_STK,
		OP_ASSIGN,
		OP_READ_FRAME,
		OP_RESTORE,
		OP_COND_INIT,
		OP_ROW_READ,
		OP_LATCH_CI,
		OP_READ_CJ,
		OP_MARK,
		OP_CNT_INIT,
		OP_CNT,
		OP_DONE
	} scc_op_t;

	typedef struct packed {
		logic root_end;
		logic root_visited;
		logic j_end;
		logic j_bit;
		logic j_visited;
		logic j_onstack;
		logic low_is_root;
		logic depth_zero;
		logic w_is_u;
		logic cnt_end;
	} scc_status_t;

endpackage

>>> src/scc_dp.sv
// Datapath: adjacency matrix, search memories, frame stack and counters.
`timescale 1ns / 1ps
module scc_dp import scc_pkg::*; #(
	parameter int MAX_NODES = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  scc_op_t     op,
	input  logic [6:0]  from_node,
	input  logic [6:0]  to_node,
	input  logic        edge_valid,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	output scc_status_t status,
	output logic [7:0]  min_sources,
	output logic [7:0]  min_added_edges,
	output logic [7:0]  component_total
);

	localparam int VW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_NODES + 1);
	localparam int FW = VW + 3 * CW;

	logic [7:0]           node_count_q;
	logic [CW-1:0]        n_q, root_q, cur_j_q, cur_low_q, cur_idx_q;
	logic [CW-1:0]        depth_q, vcnt_q, top_q, comp_q, src_q, snk_q;
	logic [VW-1:0]        cur_u_q, ci_q;
	logic [MAX_NODES-1:0] row_q;
	logic                 rv_q;
	logic [MAX_NODES-1:0] adj_valid_q, visited_q, onstack_q, hin_q, hout_q;
	logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
	logic [CW-1:0]        vo_mem [MAX_NODES];
	logic [VW-1:0]        vs_mem [MAX_NODES];
	logic [FW-1:0]        fr_mem [MAX_NODES];
	logic [VW-1:0]        cm_mem [MAX_NODES];
	logic [CW-1:0]        vo_rd_q;
	logic [VW-1:0]        vs_rd_q, cm_rd_q;
	logic [FW-1:0]        fr_rd_q;
	logic [7:0]           src_out_q, add_out_q, tot_out_q;

	logic [VW-1:0]        j_idx, root_idx, top_idx, top_m1, depth_idx, depth_m1;
	logic [VW-1:0]        enter_v, adj_ra, from_idx, to_idx, fr_u;
	logic [CW-1:0]        fr_next, fr_low, fr_idx, vcnt_inc, n_sat, max_ss;
	logic [8:0]           nc_ext;
	logic                 load_ok;
	logic [FW-1:0]        frame_wr;

	assign j_idx     = cur_j_q[VW-1:0];
	assign root_idx  = root_q[VW-1:0];
	assign top_idx   = top_q[VW-1:0];
	assign top_m1    = VW'(top_q - 1'b1);
	assign depth_idx = depth_q[VW-1:0];
	assign depth_m1  = VW'(depth_q - 1'b1);
	assign from_idx  = VW'(from_node);
	assign to_idx    = VW'(to_node);
	assign load_ok   = edge_valid && (int'(from_node) < MAX_NODES)
		&& (int'(to_node) < MAX_NODES);
	assign vcnt_inc  = CW'(vcnt_q + 1'b1);
	assign enter_v   = (op == OP_PUSH) ? j_idx : root_idx;
	assign {fr_u, fr_next, fr_low, fr_idx} = fr_rd_q;
	assign frame_wr  = {cur_u_q, CW'(cur_j_q + 1'b1), cur_low_q, cur_idx_q};
	assign nc_ext    = {1'b0, node_count_q};
	assign n_sat     = (nc_ext > 9'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(nc_ext);
	assign max_ss    = (src_q > snk_q) ? src_q : snk_q;

	always_comb begin
		case (op)
			OP_PUSH:    adj_ra = j_idx;
			OP_RESTORE: adj_ra = fr_u;
			default:    adj_ra = root_idx;
		endcase
	end

	always_comb begin
		status.root_end     = (root_q == n_q);
		status.root_visited = visited_q[root_idx];
		status.j_end        = (cur_j_q == n_q);
		status.j_bit        = rv_q & row_q[j_idx];
		status.j_visited    = visited_q[j_idx];
		status.j_onstack    = onstack_q[j_idx];
		status.low_is_root  = (cur_low_q == cur_idx_q);
		status.depth_zero   = (depth_q == '0);
		status.w_is_u       = (vs_rd_q == cur_u_q);
		status.cnt_end      = (root_q == comp_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 8'd1;
			adj_valid_q  <= '0;
			visited_q    <= '0;
			onstack_q    <= '0;
			hin_q        <= '0;
			hout_q       <= '0;
		end else begin
			if (cfg_we) begin
				node_count_q <= cfg_wdata;
			end
			case (op)
				OP_LOAD: begin
					if (load_ok) begin
						adj_valid_q[from_idx] <= 1'b1;
					end
				end
				OP_ENTER_ROOT, OP_PUSH: begin
					visited_q[enter_v] <= 1'b1;
					onstack_q[enter_v] <= 1'b1;
				end
				OP_ASSIGN: onstack_q[vs_rd_q] <= 1'b0;
				OP_MARK: begin
					if (ci_q != cm_rd_q) begin
						hout_q[ci_q]    <= 1'b1;
						hin_q[cm_rd_q]  <= 1'b1;
					end
				end
				OP_DONE: begin
					adj_valid_q <= '0;
					visited_q   <= '0;
					onstack_q   <= '0;
					hin_q       <= '0;
					hout_q      <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_INIT: begin
				n_q    <= n_sat;
				root_q <= '0;
				vcnt_q <= '0;
				top_q  <= '0;
				comp_q <= '0;
			end
			OP_NEXT_ROOT: root_q <= CW'(root_q + 1'b1);
			OP_ENTER_ROOT, OP_PUSH: begin
				cur_u_q   <= enter_v;
				cur_j_q   <= '0;
				cur_low_q <= vcnt_inc;
				cur_idx_q <= vcnt_inc;
				vcnt_q    <= vcnt_inc;
				top_q     <= CW'(top_q + 1'b1);
				depth_q   <= (op == OP_PUSH) ? CW'(depth_q + 1'b1) : '0;
			end
			OP_NEXT_J: cur_j_q <= CW'(cur_j_q + 1'b1);
			OP_UPD_LOW: begin
				if (vo_rd_q < cur_low_q) begin
					cur_low_q <= vo_rd_q;
				end
				cur_j_q <= CW'(cur_j_q + 1'b1);
			end
			OP_READ_STK: top_q <= CW'(top_q - 1'b1);
			OP_ASSIGN: begin
				if (status.w_is_u) begin
					comp_q <= CW'(comp_q + 1'b1);
				end
			end
			OP_READ_FRAME: depth_q <= CW'(depth_q - 1'b1);
			OP_RESTORE: begin
				cur_u_q   <= fr_u;
				cur_j_q   <= fr_next;
				cur_idx_q <= fr_idx;
				cur_low_q <= (cur_low_q < fr_low) ? cur_low_q : fr_low;
			end
			OP_COND_INIT: root_q <= '0;
			OP_ROW_READ: cur_j_q <= '0;
			OP_LATCH_CI: ci_q <= cm_rd_q;
			OP_MARK: cur_j_q <= CW'(cur_j_q + 1'b1);
			OP_CNT_INIT: begin
				root_q <= '0;
				src_q  <= '0;
				snk_q  <= '0;
			end
			OP_CNT: begin
				src_q  <= CW'(src_q + {{(CW-1){1'b0}}, ~hin_q[root_idx]});
				snk_q  <= CW'(snk_q + {{(CW-1){1'b0}}, ~hout_q[root_idx]});
				root_q <= CW'(root_q + 1'b1);
			end
			OP_DONE: begin
				src_out_q <= 8'(src_q);
				tot_out_q <= 8'(comp_q);
				add_out_q <= (comp_q == CW'(1)) ? 8'd0 : 8'(max_ss);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (op == OP_LOAD && load_ok) begin
			if (adj_valid_q[from_idx]) begin
				adj_mem[from_idx][to_idx] <= 1'b1;
			end else begin
				adj_mem[from_idx] <= MAX_NODES'(1) << to_idx;
			end
		end
		if (op == OP_ENTER_ROOT || op == OP_PUSH || op == OP_ROW_READ
			|| op == OP_RESTORE) begin
			row_q <= adj_mem[adj_ra];
			rv_q  <= adj_valid_q[adj_ra];
		end
		if (op == OP_ENTER_ROOT || op == OP_PUSH) begin
			vo_mem[enter_v] <= vcnt_inc;
			vs_mem[top_idx] <= enter_v;
		end
		if (op == OP_PUSH) begin
			fr_mem[depth_idx] <= frame_wr;
		end
		if (op == OP_READ_VO) begin
			vo_rd_q <= vo_mem[j_idx];
		end
		if (op == OP_READ_STK) begin
			vs_rd_q <= vs_mem[top_m1];
		end
		if (op == OP_READ_FRAME) begin
			fr_rd_q <= fr_mem[depth_m1];
		end
		if (op == OP_ASSIGN) begin
			cm_mem[vs_rd_q] <= comp_q[VW-1:0];
		end
		if (op == OP_ROW_READ) begin
			cm_rd_q <= cm_mem[root_idx];
		end else if (op == OP_READ_CJ) begin
			cm_rd_q <= cm_mem[j_idx];
		end
	end

	assign min_sources     = src_out_q;
	assign min_added_edges = add_out_q;
	assign component_total = tot_out_q;

endmodule

>>> src/scc_ctrl.sv
// Controller: sequences load, depth-first search, condensation and counting.
`timescale 1ns / 1ps
module scc_ctrl import scc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        last_item,
	input  scc_status_t status,
	output scc_op_t     op,
	output logic        busy,
	output logic        done
);

	typedef enum logic [4:0] {
		S_IDLE, S_INIT, S_ROOT, S_SCAN, S_CMPLOW, S_POP, S_SPREAD, S_SASSIGN,
		S_FINISH, S_RESTORE, S_CSTART, S_CROW, S_CROWW, S_CSCAN, S_CMARK,
		S_CNTINIT, S_CNT
	} state_t;

	state_t state_q, state_d;
	logic   busy_q, done_q;

	always_comb begin
		op      = OP_NONE;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					op = OP_LOAD;
					if (last_item) state_d = S_INIT;
				end
			end
			S_INIT: begin
				op      = OP_INIT;
				state_d = S_ROOT;
			end
			S_ROOT: begin
				if (status.root_end) begin
					state_d = S_CSTART;
				end else if (status.root_visited) begin
					op = OP_NEXT_ROOT;
				end else begin
					op      = OP_ENTER_ROOT;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (status.j_end) begin
					state_d = S_POP;
				end else if (!status.j_bit) begin
					op = OP_NEXT_J;
				end else if (!status.j_visited) begin
					op = OP_PUSH;
				end else if (status.j_onstack) begin
					op      = OP_READ_VO;
					state_d = S_CMPLOW;
				end else begin
					op = OP_NEXT_J;
				end
			end
			S_CMPLOW: begin
				op      = OP_UPD_LOW;
				state_d = S_SCAN;
			end
			S_POP: begin
				if (status.low_is_root) begin
					op      = OP_READ_STK;
					state_d = S_SASSIGN;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_SPREAD: begin
				op      = OP_READ_STK;
				state_d = S_SASSIGN;
			end
			S_SASSIGN: begin
				op      = OP_ASSIGN;
				state_d = status.w_is_u ? S_FINISH : S_SPREAD;
			end
			S_FINISH: begin
				if (status.depth_zero) begin
					op      = OP_NEXT_ROOT;
					state_d = S_ROOT;
				end else begin
					op      = OP_READ_FRAME;
					state_d = S_RESTORE;
				end
			end
			S_RESTORE: begin
				op      = OP_RESTORE;
				state_d = S_SCAN;
			end
			S_CSTART: begin
				op      = OP_COND_INIT;
				state_d = S_CROW;
			end
			S_CROW: begin
				if (status.root_end) begin
					state_d = S_CNTINIT;
				end else begin
					op      = OP_ROW_READ;
					state_d = S_CROWW;
				end
			end
			S_CROWW: begin
				op      = OP_LATCH_CI;
				state_d = S_CSCAN;
			end
			S_CSCAN: begin
				if (status.j_end) begin
					op      = OP_NEXT_ROOT;
					state_d = S_CROW;
				end else if (status.j_bit) begin
					op      = OP_READ_CJ;
					state_d = S_CMARK;
				end else begin
					op = OP_NEXT_J;
				end
			end
			S_CMARK: begin
				op      = OP_MARK;
				state_d = S_CSCAN;
			end
			S_CNTINIT: begin
				op      = OP_CNT_INIT;
				state_d = S_CNT;
			end
			S_CNT: begin
				if (status.cnt_end) begin
					op      = OP_DONE;
					state_d = S_IDLE;
				end else begin
					op = OP_CNT;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
			done_q  <= (op == OP_DONE);
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

>>> src/scc_source_sink_counter.sv
// Top level: strongly connected component counter with source and added-edge totals.
`timescale 1ns / 1ps
// Edges load one word per cycle (start high, busy low) into a bit matrix; a word with
// last_item set ends the load and raises busy. The search then walks the matrix one bit
// per cycle, pausing for the steps that push vertices, update low links, pop components or
// mark edges; the single-bit row scan runs in the depth-first search and again in the condensation
// pass. The result sits on the output ports for the one cycle that done is high and
// cannot be held off, so the receiver must take it then; busy falls in that same cycle
// and the next graph may load.
module scc_source_sink_counter import scc_pkg::*; #(
	parameter int MAX_NODES = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [6:0] from_node,
	input  logic [6:0] to_node,
	input  logic       edge_valid,
	input  logic       last_item,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	output logic       done,
	output logic [7:0] min_sources,
	output logic [7:0] min_added_edges,
	output logic [7:0] component_total
);

	scc_op_t     op;
	scc_status_t status;

	scc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.last_item (last_item),
		.status    (status),
		.op        (op),
		.busy      (busy),
		.done      (done)
	);

	scc_dp #(
		.MAX_NODES (MAX_NODES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.op              (op),
		.from_node       (from_node),
		.to_node         (to_node),
		.edge_valid      (edge_valid),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.status          (status),
		.min_sources     (min_sources),
		.min_added_edges (min_added_edges),
		.component_total (component_total)
	);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result shown while busy");

	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_item) |=> busy) else $error("last word did not start search");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");

endmodule
